FILE: sv/matrix_multiply_dot_engine_top_macros.svh
// ----------------------------------------------------------------------------
// Matrix multiply dot engine: assertion macros
// Concurrent assertion forms used by the mmde_seq module.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_DOT_ENGINE_TOP_MACROS_SVH
`define MATRIX_MULTIPLY_DOT_ENGINE_TOP_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define MMDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define MMDE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: sv/mmde_pkg.sv
// ----------------------------------------------------------------------------
// mmde_pkg
// Types, constants and helpers shared by the dot engine modules.
// ----------------------------------------------------------------------------
package mmde_pkg;

  localparam int unsigned STORE_DEPTH = 4096;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned MAX_DIM     = 64;
  localparam int unsigned DIM_W       = 7;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned ELEM_W      = 16;
  localparam int unsigned PROD_W      = 2 * ELEM_W;
  localparam int unsigned SUM_W       = 40;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned CFG_IDX_W   = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_A  = 2'd0,
    KIND_LOAD_B  = 2'd1,
    KIND_COMPUTE = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT = 2'd0,
    CFG_INNER_LEN = 2'd1,
    CFG_COL_COUNT = 2'd2,
    CFG_TRANSPOSE = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic [DIM_W-1:0] row_count;
    logic [DIM_W-1:0] inner_len;
    logic [DIM_W-1:0] col_count;
    logic             transpose_mode;
  } cfg_t;

  typedef struct packed {
    logic clr;
    logic rd_vld;
  } mac_ctrl_t;

  typedef struct packed {
    logic pipe_busy;
  } mac_stat_t;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] lim;
    lim = DIM_W'(MAX_DIM);
    return (v > lim) ? lim : v;
  endfunction

endpackage

FILE: sv/matrix_multiply_dot_engine_top.sv
// Loads (write A or write B) are taken one per cycle while the engine is idle.
// A compute sets up, then strobes an error status for an out-of-range row or
// column, or reads min(inner_len, 64) element pairs, drains and strobes; the
// next transaction is accepted in the strobe cycle. The rate is set by one
// shared multiply-accumulate fed by one read per cycle. Reset clears control,
// sets each dimension to 1 and transpose off; the element RAMs are not cleared.
// ----------------------------------------------------------------------------
// matrix_multiply_dot_engine_top
// Dense matrix multiply engine returning one Q24.16 dot product per compute
// transaction from two element RAMs.
// ----------------------------------------------------------------------------
module matrix_multiply_dot_engine_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mmde_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mmde_pkg::DIM_W-1:0]         cfg_data_i,
  input  logic                               start,
  output logic                               busy,
  input  logic [mmde_pkg::KIND_W-1:0]        kind_i,
  input  logic [11:0]                        address_i,
  input  logic signed [mmde_pkg::ELEM_W-1:0] element_value_i,
  input  logic [mmde_pkg::IDX_W-1:0]         out_row_i,
  input  logic [mmde_pkg::IDX_W-1:0]         out_col_i,
  output logic                               res_valid_o,
  output logic [mmde_pkg::IDX_W-1:0]         res_row_o,
  output logic [mmde_pkg::IDX_W-1:0]         res_col_o,
  output logic signed [mmde_pkg::SUM_W-1:0]  dot_sum_o,
  output logic                               status_o
);

  mmde_pkg::cfg_t                    cfg_q;
  mmde_pkg::mac_ctrl_t               mac_ctrl;
  mmde_pkg::mac_stat_t               mac_stat;
  logic                              accept;
  logic                              seq_busy;
  logic                              a_we;
  logic                              b_we;
  logic                              cmd_vld;
  logic [mmde_pkg::ADDR_W-1:0]       waddr;
  logic [mmde_pkg::ADDR_W-1:0]       a_raddr;
  logic [mmde_pkg::ADDR_W-1:0]       b_raddr;
  logic [mmde_pkg::ELEM_W-1:0]       a_rdata;
  logic [mmde_pkg::ELEM_W-1:0]       b_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_count      <= mmde_pkg::DIM_W'(1);
      cfg_q.inner_len      <= mmde_pkg::DIM_W'(1);
      cfg_q.col_count      <= mmde_pkg::DIM_W'(1);
      cfg_q.transpose_mode <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mmde_pkg::CFG_ROW_COUNT: cfg_q.row_count      <= cfg_data_i;
        mmde_pkg::CFG_INNER_LEN: cfg_q.inner_len      <= cfg_data_i;
        mmde_pkg::CFG_COL_COUNT: cfg_q.col_count      <= cfg_data_i;
        mmde_pkg::CFG_TRANSPOSE: cfg_q.transpose_mode <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign accept = start && !seq_busy;
  assign busy   = seq_busy;
  assign waddr  = mmde_pkg::ADDR_W'(address_i);

  always_comb begin
    a_we    = 1'b0;
    b_we    = 1'b0;
    cmd_vld = 1'b0;
    case (kind_i)
      mmde_pkg::KIND_LOAD_A:  a_we    = accept;
      mmde_pkg::KIND_LOAD_B:  b_we    = accept;
      mmde_pkg::KIND_COMPUTE: cmd_vld = accept;
      default: begin
      end
    endcase
  end

  mmde_ram #(
    .WIDTH (mmde_pkg::ELEM_W),
    .DEPTH (mmde_pkg::STORE_DEPTH)
  ) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (waddr),
    .wdata_i (element_value_i),
    .re_i    (mac_ctrl.rd_vld),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mmde_ram #(
    .WIDTH (mmde_pkg::ELEM_W),
    .DEPTH (mmde_pkg::STORE_DEPTH)
  ) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (waddr),
    .wdata_i (element_value_i),
    .re_i    (mac_ctrl.rd_vld),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  mmde_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_vld_i  (cmd_vld),
    .out_row_i  (out_row_i),
    .out_col_i  (out_col_i),
    .cfg_i      (cfg_q),
    .busy_o     (seq_busy),
    .a_raddr_o  (a_raddr),
    .b_raddr_o  (b_raddr),
    .mac_ctrl_o (mac_ctrl),
    .mac_stat_i (mac_stat),
    .res_vld_o  (res_valid_o),
    .res_row_o  (res_row_o),
    .res_col_o  (res_col_o),
    .status_o   (status_o)
  );

  mmde_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .a_data_i (a_rdata),
    .b_data_i (b_rdata),
    .stat_o   (mac_stat),
    .acc_o    (dot_sum_o)
  );

endmodule

FILE: sv/mmde_ram.sv
// ----------------------------------------------------------------------------
// mmde_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mmde_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/mmde_mac.sv
// ----------------------------------------------------------------------------
// mmde_mac
// Shared multiply-accumulate unit: registered product, then 40-bit sum.
// ----------------------------------------------------------------------------
module mmde_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mmde_pkg::mac_ctrl_t                 ctrl_i,
  input  logic [mmde_pkg::ELEM_W-1:0]         a_data_i,
  input  logic [mmde_pkg::ELEM_W-1:0]         b_data_i,
  output mmde_pkg::mac_stat_t                 stat_o,
  output logic signed [mmde_pkg::SUM_W-1:0]   acc_o
);

  logic                                 v1_q;
  logic                                 v2_q;
  logic signed [mmde_pkg::PROD_W-1:0]   prod_q;
  logic signed [mmde_pkg::SUM_W-1:0]    acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= ctrl_i.rd_vld;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      prod_q <= $signed(a_data_i) * $signed(b_data_i);
    end
    if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + mmde_pkg::SUM_W'(prod_q);
    end
  end

  assign stat_o.pipe_busy = v1_q | v2_q;
  assign acc_o            = acc_q;

endmodule

FILE: sv/mmde_seq.sv
// ----------------------------------------------------------------------------
// mmde_seq
// Sequencer for one compute transaction: range check, address walk over the
// inner dimension, pipeline drain and result strobe.
// ----------------------------------------------------------------------------
`include "matrix_multiply_dot_engine_top_macros.svh"

module mmde_seq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_vld_i,
  input  logic [mmde_pkg::IDX_W-1:0]        out_row_i,
  input  logic [mmde_pkg::IDX_W-1:0]        out_col_i,
  input  mmde_pkg::cfg_t                    cfg_i,
  output logic                              busy_o,
  output logic [mmde_pkg::ADDR_W-1:0]       a_raddr_o,
  output logic [mmde_pkg::ADDR_W-1:0]       b_raddr_o,
  output mmde_pkg::mac_ctrl_t               mac_ctrl_o,
  input  mmde_pkg::mac_stat_t               mac_stat_i,
  output logic                              res_vld_o,
  output logic [mmde_pkg::IDX_W-1:0]        res_row_o,
  output logic [mmde_pkg::IDX_W-1:0]        res_col_o,
  output logic                              status_o
);

  localparam int unsigned MUL_W = mmde_pkg::IDX_W + mmde_pkg::DIM_W;

  mmde_pkg::state_e                 state_q, state_d;
  logic [mmde_pkg::IDX_W-1:0]       row_q, row_d;
  logic [mmde_pkg::IDX_W-1:0]       col_q, col_d;
  logic [mmde_pkg::DIM_W-1:0]       kl_q, kl_d;
  logic [mmde_pkg::DIM_W-1:0]       step_q, step_d;
  logic [mmde_pkg::DIM_W-1:0]       cnt_q, cnt_d;
  logic [mmde_pkg::ADDR_W-1:0]      a_addr_q, a_addr_d;
  logic [mmde_pkg::ADDR_W-1:0]      b_addr_q, b_addr_d;
  logic                             res_vld_q, res_vld_d;
  logic                             status_q, status_d;

  logic [mmde_pkg::DIM_W-1:0]       rows_c;
  logic [mmde_pkg::DIM_W-1:0]       kl_c;
  logic [mmde_pkg::DIM_W-1:0]       cols_c;
  logic                             bad_c;
  logic [MUL_W-1:0]                 a_base_c;
  logic [MUL_W-1:0]                 c_base_c;

  assign rows_c   = mmde_pkg::clamp_dim(cfg_i.row_count);
  assign kl_c     = mmde_pkg::clamp_dim(cfg_i.inner_len);
  assign cols_c   = mmde_pkg::clamp_dim(cfg_i.col_count);
  assign bad_c    = (mmde_pkg::DIM_W'(row_q) >= rows_c) ||
                    (mmde_pkg::DIM_W'(col_q) >= cols_c);
  assign a_base_c = MUL_W'(row_q) * MUL_W'(kl_c);
  assign c_base_c = MUL_W'(col_q) * MUL_W'(kl_c);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mmde_pkg::ST_IDLE;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q    <= row_d;
    col_q    <= col_d;
    kl_q     <= kl_d;
    step_q   <= step_d;
    cnt_q    <= cnt_d;
    a_addr_q <= a_addr_d;
    b_addr_q <= b_addr_d;
    status_q <= status_d;
  end

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    col_d      = col_q;
    kl_d       = kl_q;
    step_d     = step_q;
    cnt_d      = cnt_q;
    a_addr_d   = a_addr_q;
    b_addr_d   = b_addr_q;
    res_vld_d  = 1'b0;
    status_d   = status_q;
    mac_ctrl_o = '0;
    case (state_q)
      mmde_pkg::ST_IDLE: begin
        if (cmd_vld_i) begin
          row_d   = out_row_i;
          col_d   = out_col_i;
          state_d = mmde_pkg::ST_SETUP;
        end
      end
      mmde_pkg::ST_SETUP: begin
        mac_ctrl_o.clr = 1'b1;
        kl_d           = kl_c;
        cnt_d          = '0;
        a_addr_d       = mmde_pkg::ADDR_W'(a_base_c);
        if (cfg_i.transpose_mode) begin
          b_addr_d = mmde_pkg::ADDR_W'(c_base_c);
          step_d   = mmde_pkg::DIM_W'(1);
        end else begin
          b_addr_d = mmde_pkg::ADDR_W'(col_q);
          step_d   = cols_c;
        end
        if (bad_c) begin
          res_vld_d = 1'b1;
          status_d  = 1'b1;
          state_d   = mmde_pkg::ST_IDLE;
        end else begin
          status_d = 1'b0;
          state_d  = mmde_pkg::ST_RUN;
        end
      end
      mmde_pkg::ST_RUN: begin
        if (cnt_q != kl_q) begin
          mac_ctrl_o.rd_vld = 1'b1;
          cnt_d             = cnt_q + mmde_pkg::DIM_W'(1);
          a_addr_d          = a_addr_q + mmde_pkg::ADDR_W'(1);
          b_addr_d          = b_addr_q + mmde_pkg::ADDR_W'(step_q);
        end else if (!mac_stat_i.pipe_busy) begin
          res_vld_d = 1'b1;
          state_d   = mmde_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mmde_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o    = (state_q != mmde_pkg::ST_IDLE);
  assign a_raddr_o = a_addr_q;
  assign b_raddr_o = b_addr_q;
  assign res_vld_o = res_vld_q;
  assign res_row_o = row_q;
  assign res_col_o = col_q;
  assign status_o  = status_q;

  `MMDE_ASSERT_ALWAYS(a_no_res_in_rst, !rst_ni |=> !res_vld_q, "result strobe during reset")
  `MMDE_ASSERT(a_res_after_work, res_vld_q |-> $past(state_q) != mmde_pkg::ST_IDLE, "stray result")
  `MMDE_ASSERT(a_cnt_bound, (state_q == mmde_pkg::ST_RUN) |-> (cnt_q <= kl_q), "count overrun")
  `MMDE_ASSERT(a_ok_drained, (res_vld_q && !status_q) |-> !mac_stat_i.pipe_busy, "early result")
  `MMDE_ASSERT(a_setup_exit, (state_q == mmde_pkg::ST_SETUP) |=> (state_q == mmde_pkg::ST_RUN) || res_vld_q, "bad setup exit")

endmodule
